@@ design/unh_pkg.sv @@
// shared types, constants and helpers for the utf-8 n-gram hasher
// used by unh_hash_cell, unh_gram_seq and utf8_ngram_hasher; no dependencies
package unh_pkg;

    // parameter defaults
    localparam int MAX_GRAM_CHARS_DEF    = 4;
    localparam int WINDOW_BYTE_DEPTH_DEF = 16;

    // fnv-1a 32-bit
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // utf-8 lead byte masks and patterns
    localparam logic [7:0] MASK_1 = 8'h80;
    localparam logic [7:0] MASK_2 = 8'hE0;
    localparam logic [7:0] PAT_2  = 8'hC0;
    localparam logic [7:0] MASK_3 = 8'hF0;
    localparam logic [7:0] PAT_3  = 8'hE0;
    localparam logic [7:0] MASK_4 = 8'hF8;
    localparam logic [7:0] PAT_4  = 8'hF0;

    // per-string character count saturates here
    localparam logic [2:0] SEEN_CAP = 3'd7;

    // results one byte can cause
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = 2;

    // gram modes
    localparam logic [1:0] MODE_FIXED = 2'd0;
    localparam logic [1:0] MODE_ALL   = 2'd1;
    localparam logic [1:0] MODE_AUTO  = 2'd2;

    // configuration register indexes
    localparam int         CFG_INDEX_W     = 1;
    localparam int         CFG_DATA_W      = 3;
    localparam logic [0:0] CFG_MODE_SELECT = 1'b0;
    localparam logic [0:0] CFG_GRAM_SIZE   = 1'b1;

    // input item
    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } byte_item_t;

    // result item
    typedef struct packed {
        logic [31:0] hash_value;
        logic [2:0]  gram_chars;
        logic        last_of_run;
    } gram_item_t;

    // control to each cell of the hash row
    typedef struct packed {
        logic       shift;
        logic       capture;
        logic [7:0] byte_value;
    } cell_ctl_t;

    // grams requested by one accepted byte
    typedef struct packed {
        logic                             load;
        logic [CNT_W-1:0]                 cnt;
        logic [MAX_RESULTS-1:0][2:0]      k;
        logic [1:0]                       skip;
    } gram_batch_t;

    // character length given by a lead byte; stray bytes count as one
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        priority if ((b & MASK_1) == 8'h00) len = 3'd1;
        else if ((b & MASK_2) == PAT_2)     len = 3'd2;
        else if ((b & MASK_3) == PAT_3)     len = 3'd3;
        else if ((b & MASK_4) == PAT_4)     len = 3'd4;
        else                                len = 3'd1;
        return len;
    endfunction

endpackage

@@ design/unh_hash_cell.sv @@
// one cell of the hash row: running fnv-1a hash from its window position
// to the newest byte, and a copy frozen at the last completed character
// depends on unh_pkg
module unh_hash_cell
    import unh_pkg::*;
(
    input  logic        clk,
    input  cell_ctl_t   ctl,
    input  logic [31:0] h_in,
    input  logic [31:0] g_in,
    output logic [31:0] h_out,
    output logic [31:0] g_out
);

    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] g_reg;
    logic [31:0] g_next;

    // fold the new byte into the neighbor's hash
    always_comb
    begin
        h_next = (h_in ^ {24'd0, ctl.byte_value}) * FNV_PRIME;
        g_next = ctl.capture ? h_next : g_in;
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            h_reg <= h_next;
            g_reg <= g_next;
        end
    end

    assign h_out = h_reg;
    assign g_out = g_reg;

endmodule

@@ design/unh_gram_seq.sv @@
// gram sequencer: holds the grams one byte requested, reads their hashes
// from the cell row one per cycle while the output register is free and
// drives that result register; depends on unh_pkg
module unh_gram_seq
    import unh_pkg::*;
#(
    parameter int MAX_GRAM_CHARS    = MAX_GRAM_CHARS_DEF,
    parameter int WINDOW_BYTE_DEPTH = WINDOW_BYTE_DEPTH_DEF,
    localparam int IDX_W = $clog2(WINDOW_BYTE_DEPTH),
    localparam int TOT_W = $clog2(MAX_GRAM_CHARS * 4 + 1),
    localparam int SUM_W = $clog2(WINDOW_BYTE_DEPTH + MAX_GRAM_CHARS * 4 + 4)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  gram_batch_t      batch,
    input  logic [2:0]       char_len [MAX_GRAM_CHARS],
    input  logic [31:0]      rd_hash,
    output logic [IDX_W-1:0] rd_idx,
    output logic             can_load,
    output logic             gram_valid,
    input  logic             gram_ready,
    output gram_item_t       gram_data
);

    logic [CNT_W-1:0]            pend_cnt_reg;
    logic [CNT_W-1:0]            pend_cnt_next;
    logic [MAX_RESULTS-1:0][2:0] pend_k_reg;
    logic [MAX_RESULTS-1:0][2:0] pend_k_next;
    logic [1:0]                  skip_reg;
    logic [1:0]                  skip_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    gram_item_t                  out_data_reg;
    logic                        emit;
    logic [TOT_W-1:0]            total;
    logic [SUM_W-1:0]            span;

    // byte span of the head gram, newest characters first
    always_comb
    begin
        total = '0;
        for (int i = 0; i < MAX_GRAM_CHARS; i++)
        begin
            if (i < int'(pend_k_reg[0]))
                total = total + TOT_W'(char_len[MAX_GRAM_CHARS - 1 - i]);
        end
    end

    // start position in the row; a gram longer than the row starts at the oldest cell
    always_comb
    begin
        span = SUM_W'(total) + SUM_W'(skip_reg);
        if (span >= SUM_W'(WINDOW_BYTE_DEPTH))
            rd_idx = '0;
        else
            rd_idx = IDX_W'(SUM_W'(WINDOW_BYTE_DEPTH) - span);
    end

    // move the head gram into the output register when it is free
    assign emit     = (pend_cnt_reg != '0) && (!out_valid_reg || gram_ready);
    assign can_load = (pend_cnt_reg == '0) || ((pend_cnt_reg == CNT_W'(1)) && emit);

    always_comb
    begin
        pend_cnt_next  = pend_cnt_reg;
        pend_k_next    = pend_k_reg;
        skip_next      = skip_reg;
        out_valid_next = out_valid_reg;
        if (gram_ready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            out_valid_next = 1'b1;
            pend_cnt_next  = pend_cnt_reg - CNT_W'(1);
            for (int i = 0; i + 1 < MAX_RESULTS; i++)
                pend_k_next[i] = pend_k_reg[i + 1];
            pend_k_next[MAX_RESULTS - 1] = 3'd0;
        end
        if (batch.load)
        begin
            pend_cnt_next = batch.cnt;
            pend_k_next   = batch.k;
            skip_next     = batch.skip;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pend_k_reg <= pend_k_next;
        skip_reg   <= skip_next;
        if (emit)
        begin
            out_data_reg.hash_value  <= rd_hash;
            out_data_reg.gram_chars  <= pend_k_reg[0];
            out_data_reg.last_of_run <= (pend_cnt_reg == CNT_W'(1));
        end
    end

    assign gram_valid = out_valid_reg;
    assign gram_data  = out_data_reg;

endmodule

@@ design/utf8_ngram_hasher.sv @@
// top level of the utf-8 character n-gram hasher (fnv-1a 32-bit)
// depends on unh_pkg, unh_hash_cell and unh_gram_seq
//
// usage:
//   byte channel (byte_valid/byte_ready/byte_data) takes one text byte per
//   transfer; last_byte marks the end of a string.
//   gram channel (gram_valid/gram_ready/gram_data) gives one gram hash per
//   transfer; last_of_run is set on the final gram caused by a byte.
//   cfg_write/cfg_index/cfg_data write mode_select (0) and gram_size (1) while idle.
// grams: a byte transfer loads its grams (0 to 3) as pending in the sequencer;
//   each moves into the output register when that register is free, and one
//   gram hash is read from the cell row per cycle while it stays free; the
//   next byte is taken once the last pending gram moves out.
// the cell row updates every running hash with each byte, so no byte scan
//   is needed to form a gram.
// reset: fixed mode with gram size 3, character tracking cleared; the cell
//   row holds no reset and is only read where written.
// stall: while the receiver holds gram_ready low, pending grams wait; byte_ready
//   is low while more than one gram is pending, or one is pending and the
//   output register cannot take it.
module utf8_ngram_hasher
    import unh_pkg::*;
#(
    parameter int MAX_GRAM_CHARS    = MAX_GRAM_CHARS_DEF,
    parameter int WINDOW_BYTE_DEPTH = WINDOW_BYTE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  byte_item_t             byte_data,
    output logic                   gram_valid,
    input  logic                   gram_ready,
    output gram_item_t             gram_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CIW_W = $clog2(MAX_GRAM_CHARS + 1);
    localparam int IDX_W = $clog2(WINDOW_BYTE_DEPTH);

    logic [1:0]       mode_select_reg;
    logic [2:0]       gram_size_reg;
    logic [1:0]       bytes_left_reg;
    logic [1:0]       bytes_left_next;
    logic [2:0]       lead_len_reg;
    logic [2:0]       lead_len_next;
    logic [CIW_W-1:0] ciw_reg;
    logic [CIW_W-1:0] ciw_next;
    logic [2:0]       seen_reg;
    logic [2:0]       seen_next;
    logic [2:0]       char_len_reg [MAX_GRAM_CHARS];

    logic             accept;
    logic             done;
    logic [2:0]       b_len;
    logic [2:0]       char_len_new;
    logic [1:0]       left_after;
    logic [2:0]       lead_after;
    logic [CIW_W-1:0] ciw_inc;
    logic [2:0]       seen_inc;
    logic [1:0]       skip;
    gram_batch_t      batch;
    cell_ctl_t        cell_ctl;
    logic [31:0]      h_row [WINDOW_BYTE_DEPTH];
    logic [31:0]      g_row [WINDOW_BYTE_DEPTH];
    logic [IDX_W-1:0] rd_idx;
    logic             can_load;

    assign accept     = byte_valid && byte_ready;
    assign byte_ready = can_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_select_reg <= MODE_FIXED;
            gram_size_reg   <= 3'd3;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_MODE_SELECT)
                mode_select_reg <= cfg_data[1:0];
            else if (cfg_index == CFG_GRAM_SIZE)
                gram_size_reg <= cfg_data[2:0];
        end
    end

    // utf-8 character tracking
    always_comb
    begin
        b_len = lead_len(byte_data.byte_value);
        if (bytes_left_reg == 2'd0)
        begin
            done         = (b_len == 3'd1);
            char_len_new = b_len;
            left_after   = done ? 2'd0 : 2'(b_len - 3'd1);
            lead_after   = done ? lead_len_reg : b_len;
        end
        else
        begin
            left_after   = bytes_left_reg - 2'd1;
            done         = (left_after == 2'd0);
            char_len_new = lead_len_reg;
            lead_after   = lead_len_reg;
        end
        ciw_inc  = ciw_reg;
        seen_inc = seen_reg;
        if (done)
        begin
            if (ciw_reg < CIW_W'(MAX_GRAM_CHARS))
                ciw_inc = ciw_reg + CIW_W'(1);
            if (seen_reg < SEEN_CAP)
                seen_inc = seen_reg + 3'd1;
        end
        // bytes of the unfinished character at a string end
        skip = (left_after != 2'd0) ? 2'(lead_after - {1'b0, left_after}) : 2'd0;
    end

    // next tracking state; a string end clears it
    always_comb
    begin
        bytes_left_next = left_after;
        lead_len_next   = lead_after;
        ciw_next        = ciw_inc;
        seen_next       = seen_inc;
        if (byte_data.last_byte)
        begin
            bytes_left_next = 2'd0;
            lead_len_next   = 3'd0;
            ciw_next        = '0;
            seen_next       = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 2'd0;
            lead_len_reg   <= 3'd0;
            ciw_reg        <= '0;
            seen_reg       <= 3'd0;
        end
        else if (accept)
        begin
            bytes_left_reg <= bytes_left_next;
            lead_len_reg   <= lead_len_next;
            ciw_reg        <= ciw_next;
            seen_reg       <= seen_next;
        end
    end

    // lengths of the newest characters, newest at the top
    always_ff @(posedge clk)
    begin
        if (accept && done)
        begin
            for (int i = 0; i + 1 < MAX_GRAM_CHARS; i++)
                char_len_reg[i] <= char_len_reg[i + 1];
            char_len_reg[MAX_GRAM_CHARS - 1] <= char_len_new;
        end
    end

    // grams requested by this byte
    always_comb
    begin
        batch      = '0;
        batch.load = accept;
        batch.skip = 2'd0;
        unique case (mode_select_reg)
            MODE_FIXED:
            begin
                if (done && (gram_size_reg != 3'd0) &&
                    (4'(gram_size_reg) <= 4'(MAX_GRAM_CHARS)) &&
                    (4'(ciw_inc) >= 4'(gram_size_reg)))
                begin
                    batch.cnt  = CNT_W'(1);
                    batch.k[0] = gram_size_reg;
                end
            end
            MODE_ALL:
            begin
                if (done)
                begin
                    batch.cnt  = (4'(ciw_inc) >= 4'd3) ? CNT_W'(3) : ciw_inc[1:0];
                    batch.k[0] = 3'd1;
                    batch.k[1] = 3'd2;
                    batch.k[2] = 3'd3;
                end
            end
            MODE_AUTO:
            begin
                if (done && (4'(ciw_inc) >= 4'd3))
                begin
                    batch.cnt  = CNT_W'(1);
                    batch.k[0] = 3'd3;
                end
                else if (byte_data.last_byte && (seen_inc == 3'd1 || seen_inc == 3'd2))
                begin
                    batch.cnt  = CNT_W'(1);
                    batch.k[0] = seen_inc;
                    batch.skip = skip;
                end
            end
            default:
            begin
                batch.cnt = '0;
            end
        endcase
    end

    // row of hash cells, oldest position at index zero
    assign cell_ctl.shift      = accept;
    assign cell_ctl.capture    = done;
    assign cell_ctl.byte_value = byte_data.byte_value;

    for (genvar gi = 0; gi < WINDOW_BYTE_DEPTH; gi++)
    begin : g_cell
        logic [31:0] h_in;
        logic [31:0] g_in;
        if (gi == WINDOW_BYTE_DEPTH - 1)
        begin : g_newest
            assign h_in = FNV_BASIS;
            assign g_in = FNV_BASIS;
        end
        else
        begin : g_inner
            assign h_in = h_row[gi + 1];
            assign g_in = g_row[gi + 1];
        end
        unh_hash_cell u_cell (
            .clk   (clk),
            .ctl   (cell_ctl),
            .h_in  (h_in),
            .g_in  (g_in),
            .h_out (h_row[gi]),
            .g_out (g_row[gi])
        );
    end

    // gram sequencer and output register
    unh_gram_seq #(
        .MAX_GRAM_CHARS    (MAX_GRAM_CHARS),
        .WINDOW_BYTE_DEPTH (WINDOW_BYTE_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .batch      (batch),
        .char_len   (char_len_reg),
        .rd_hash    (g_row[rd_idx]),
        .rd_idx     (rd_idx),
        .can_load   (can_load),
        .gram_valid (gram_valid),
        .gram_ready (gram_ready),
        .gram_data  (gram_data)
    );

    // fixed mode never asks for more than one gram per byte
    a_fixed_single: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_select_reg == MODE_FIXED) |-> (batch.cnt <= CNT_W'(1)))
        else $error("fixed mode requested more than one gram");

    // continuation count stays below the length of the character in progress
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg != 2'd0) |-> ({1'b0, bytes_left_reg} < lead_len_reg))
        else $error("continuation count exceeds character length");

    // a string end clears the character tracking
    a_string_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && byte_data.last_byte) |=>
        (ciw_reg == '0 && bytes_left_reg == 2'd0 && seen_reg == 3'd0))
        else $error("tracking not cleared after string end");

endmodule
